// File: hw/rtl/websocket_frame_deframer_top_macros.svh
// Assertion macros shared by the WebSocket deframer RTL.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
`default_nettype none

package wsfd_pkg;

  localparam int unsigned LenW = 64;
  localparam int unsigned KeyW = 32;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Record kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef struct packed {
    logic            kind;
    logic [7:0]      payload_byte;
    logic            frame_fin;
    logic [3:0]      frame_opcode;
    logic            frame_masked;
    logic [LenW-1:0] payload_length;
    logic            last_of_frame;
  } wsfd_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/wsfd_if.sv
// Stream interfaces for the deframer: byte input and record output.
// Depends on nothing; field widths match the package result record.
`default_nettype none

interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        frame_fin;
  logic [3:0]  frame_opcode;
  logic        frame_masked;
  logic [63:0] payload_length;
  logic        last_of_frame;

  modport source (output valid, output kind, output payload_byte, output frame_fin,
                  output frame_opcode, output frame_masked, output payload_length,
                  output last_of_frame, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_fin,
                  input frame_opcode, input frame_masked, input payload_length,
                  input last_of_frame, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wsfd_parser.sv
// Frame parser: header state machine, length and key capture, payload unmasking.
// Depends on wsfd_pkg and the assertion macro header.
`default_nettype none

module wsfd_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [7:0]            byte_i,
  output logic                       emit_o,
  output wsfd_pkg::wsfd_result_t     res_o
);
  import wsfd_pkg::*;

  `include "websocket_frame_deframer_top_macros.svh"

  phase_e            phase_q, phase_d;
  logic [2:0]        idx_q, idx_d;
  logic              fin_q, fin_d;
  logic [3:0]        op_q, op_d;
  logic              masked_q, masked_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [1:0]        kidx_q, kidx_d;

  logic              hdr_done;
  logic              key_start;
  logic [7:0]        key_byte;
  logic [7:0]        data_byte;
  logic              data_last;

  // Key byte for the current payload position; the first key byte is the top one.
  always_comb begin
    unique case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign data_byte = masked_q ? (byte_i ^ key_byte) : byte_i;
  assign data_last = (rem_q == LenW'(1));

  // Next state of the parser and the record produced by this byte.
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    fin_d     = fin_q;
    op_d      = op_q;
    masked_d  = masked_q;
    len_d     = len_q;
    key_d     = key_q;
    rem_d     = rem_q;
    kidx_d    = kidx_q;
    hdr_done  = 1'b0;
    key_start = 1'b0;
    emit_o    = 1'b0;
    res_o     = '0;

    unique case (phase_q)
      PH_HDR1: begin
        masked_d = byte_i[7];
        idx_d    = '0;
        if (byte_i[6:0] == LEN_CODE_EXT16) begin
          len_d   = '0;
          phase_d = PH_EXT16;
        end else if (byte_i[6:0] == LEN_CODE_EXT64) begin
          len_d   = '0;
          phase_d = PH_EXT64;
        end else begin
          len_d = LenW'(byte_i[6:0]);
          if (byte_i[7]) begin
            key_start = 1'b1;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT16: begin
        len_d = LenW'({len_q[7:0], byte_i});
        if (idx_q >= 3'd1) begin
          idx_d = '0;
          if (masked_q) begin
            key_start = 1'b1;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PH_EXT64: begin
        len_d = {len_q[LenW-9:0], byte_i};
        if (idx_q == 3'd7) begin
          idx_d = '0;
          if (masked_q) begin
            key_start = 1'b1;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[KeyW-9:0], byte_i};
        if (idx_q >= 3'd3) begin
          hdr_done = 1'b1;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        rem_d  = rem_q - LenW'(1);
        kidx_d = kidx_q + 2'd1;
        emit_o = 1'b1;
        res_o.kind          = KIND_PAYLOAD;
        res_o.payload_byte  = data_byte;
        res_o.last_of_frame = data_last;
        if (data_last) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        fin_d   = byte_i[7];
        op_d    = byte_i[3:0];
        idx_d   = '0;
        phase_d = PH_HDR1;
      end
    endcase

    // Masked frame: collect the four key bytes next.
    if (key_start) begin
      key_d   = '0;
      phase_d = PH_KEY;
    end

    // Header complete: emit the header record and arm the payload counters.
    if (hdr_done) begin
      idx_d  = '0;
      rem_d  = len_d;
      kidx_d = '0;
      emit_o = 1'b1;
      res_o.kind          = KIND_HEADER;
      res_o.last_of_frame = (len_d == '0);
      phase_d = (len_d == '0) ? PH_HDR0 : PH_PAYLOAD;
    end

    // Frame attributes always reflect the updated frame state.
    res_o.frame_fin      = fin_d;
    res_o.frame_opcode   = op_d;
    res_o.frame_masked   = masked_d;
    res_o.payload_length = len_d;
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      op_q     <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      key_q    <= '0;
      rem_q    <= '0;
      kidx_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      kidx_q   <= kidx_d;
    end
  end

  // A frame in its payload phase always has bytes left to deliver.
  `WSFD_ASSERT_IMP(a_rem_nonzero, phase_q == PH_PAYLOAD, rem_q != '0, "payload phase with no bytes left")
  // A header record is flagged last exactly when the frame is empty.
  `WSFD_ASSERT_IMP(a_hdr_last, step_i && emit_o && (res_o.kind == KIND_HEADER), res_o.last_of_frame == (len_d == '0), "header last flag disagrees with length")
  // The final payload byte returns the parser to the first header byte.
  `WSFD_ASSERT_NXT(a_last_to_hdr0, step_i && (phase_q == PH_PAYLOAD) && data_last, phase_q == PH_HDR0, "parser did not return to header start")

endmodule

`default_nettype wire

// File: hw/rtl/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsfd_pkg, wsfd_if, wsfd_parser and the assertion macro header.
//
//   Channel | Dir | Content                                   | Transfer when
//   byte_i  | in  | one byte of the frame stream              | valid & ready
//   rec_o   | out | header record or one unmasked payload byte | valid & ready
//
// One byte is taken per cycle while byte_i.ready is high. Each byte is held in the byte
// register, passes through the parser, and any record it yields is held in the result
// register for output. The parser is a single combinational pass between the two registers.
// Reset is asynchronous and returns the parser to the first header byte. A stalled
// output holds its record and one more byte still enters the byte register;
// byte_i.ready drops only when both registers are full.
`default_nettype none

module websocket_frame_deframer_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  wsfd_in_if.sink       byte_i,
  wsfd_out_if.source    rec_o
);
  import wsfd_pkg::*;

  `include "websocket_frame_deframer_top_macros.svh"

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  wsfd_result_t out_q;

  logic         advance;
  logic         step;
  logic         emit;
  wsfd_result_t res;

  // The result register can load when empty or being drained this cycle.
  assign advance      = !out_valid_q || rec_o.ready;
  assign step         = in_valid_q && advance;
  assign byte_i.ready = !in_valid_q || advance;

  // Input byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.in_byte;
    end
  end

  wsfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .emit_o (emit),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign rec_o.valid          = out_valid_q;
  assign rec_o.kind           = out_q.kind;
  assign rec_o.payload_byte   = out_q.payload_byte;
  assign rec_o.frame_fin      = out_q.frame_fin;
  assign rec_o.frame_opcode   = out_q.frame_opcode;
  assign rec_o.frame_masked   = out_q.frame_masked;
  assign rec_o.payload_length = out_q.payload_length;
  assign rec_o.last_of_frame  = out_q.last_of_frame;

  // Both registers full and the output stalled: no byte may enter.
  `WSFD_ASSERT_IMP(a_full_backpressure, in_valid_q && out_valid_q && !rec_o.ready, !byte_i.ready, "byte accepted while pipeline full")
  // With no byte waiting, the result register empties once it may advance.
  `WSFD_ASSERT_NXT(a_no_phantom, !in_valid_q && advance, !out_valid_q, "result without a parsed byte")
  // A consumed byte leaves the input register empty unless a new one arrives.
  `WSFD_ASSERT_NXT(a_in_drain, step && !byte_i.valid, !in_valid_q, "input register kept a consumed byte")

endmodule

`default_nettype wire

// File: tb/websocket_frame_deframer_top_tb.sv
// Self-checking testbench for the WebSocket frame deframer top level.
// Depends on wsfd_pkg, the wsfd_in_if / wsfd_out_if interfaces and the RTL top.
// A byte-stream predictor checks every header record and payload byte the block emits.
module websocket_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfd_pkg::*;

  localparam int unsigned STREAM_BYTES = 600;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_enc_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // One entry of the byte stream, or a marker that holds the sender until the output drains.
  typedef struct packed {
    logic       hold;
    logic [7:0] data;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wsfd_in_if  byte_if ();
  wsfd_out_if rec_if ();

  websocket_frame_deframer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .rec_o  (rec_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stim_t        stim_q[$];
  wsfd_result_t pending_rec_q[$];

  int unsigned stream_bytes;
  int unsigned bytes_taken;
  int unsigned frames, masked_frames, ext16_frames, ext64_frames, empty_frames;
  int unsigned hdr_recs, pay_recs, holds_done;
  int unsigned err_cnt;

  // Deframer state mirrored by the predictor.
  phase_e      ph_q     = PH_HDR0;
  logic [2:0]  idx_q    = '0;
  logic        fin_q    = 1'b0;
  logic [3:0]  opc_q    = '0;
  logic        masked_q = 1'b0;
  logic [63:0] len_q    = '0;
  logic [31:0] key_q    = '0;
  logic [63:0] cnt_q    = '0;

  function automatic void emit_rec(input logic kind, input logic [7:0] pbyte, input logic last);
    wsfd_result_t r;
    r.kind           = kind;
    r.payload_byte   = pbyte;
    r.frame_fin      = fin_q;
    r.frame_opcode   = opc_q;
    r.frame_masked   = masked_q;
    r.payload_length = len_q;
    r.last_of_frame  = last;
    pending_rec_q.push_back(r);
  endfunction

  // Header complete: an empty frame closes here, otherwise payload follows.
  function automatic void close_header();
    cnt_q = '0;
    idx_q = '0;
    if (len_q == 64'd0) begin
      emit_rec(KIND_HEADER, 8'h00, 1'b1);
      ph_q = PH_HDR0;
    end else begin
      emit_rec(KIND_HEADER, 8'h00, 1'b0);
      ph_q = PH_PAYLOAD;
    end
  endfunction

  function automatic void length_done();
    idx_q = '0;
    if (masked_q) begin
      key_q = '0;
      ph_q  = PH_KEY;
    end else begin
      close_header();
    end
  endfunction

  // Advance the parser by one stream byte and queue the record it produces, if any.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    case (ph_q)
      PH_HDR1: begin
        masked_q = b[7];
        idx_q    = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          len_q = '0;
          ph_q  = PH_EXT16;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          len_q = '0;
          ph_q  = PH_EXT64;
        end else begin
          len_q = {57'd0, b[6:0]};
          length_done();
        end
      end
      PH_EXT16: begin
        len_q = {48'd0, len_q[7:0], b};
        if (idx_q >= 3'd1) length_done();
        else idx_q = idx_q + 3'd1;
      end
      PH_EXT64: begin
        len_q = {len_q[55:0], b};
        if (idx_q >= 3'd7) length_done();
        else idx_q = idx_q + 3'd1;
      end
      PH_KEY: begin
        key_q = {key_q[23:0], b};
        if (idx_q >= 3'd3) close_header();
        else idx_q = idx_q + 3'd1;
      end
      PH_PAYLOAD: begin
        // Key bytes are applied first byte first, cycling every four payload bytes.
        if (masked_q) v = b ^ key_q[8 * (3 - cnt_q[1:0]) +: 8];
        cnt_q = cnt_q + 64'd1;
        emit_rec(KIND_PAYLOAD, v, cnt_q == len_q);
        if (cnt_q == len_q) ph_q = PH_HDR0;
      end
      default: begin
        fin_q = b[7];
        opc_q = b[3:0];
        idx_q = '0;
        ph_q  = PH_HDR1;
      end
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    stim_q.push_back('{hold: 1'b0, data: b});
    stream_bytes++;
  endfunction

  // Append one frame; n_pay may be shorter than len only for the closing frame.
  function automatic void queue_frame(input logic [7:0] b0, input logic masked,
                                      input len_enc_e enc, input logic [63:0] len,
                                      input logic [31:0] key, input int unsigned n_pay);
    push_byte(b0);
    case (enc)
      LEN_EXT16: begin
        push_byte({masked, LEN_CODE_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        ext16_frames++;
      end
      LEN_EXT64: begin
        push_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
        ext64_frames++;
      end
      default: push_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
      masked_frames++;
    end
    for (int unsigned i = 0; i < n_pay; i++) push_byte(8'($urandom));
    if (len == 64'd0) empty_frames++;
    frames++;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    logic [7:0] next_b;
    logic       send;
    if (!rst_ni) begin
      byte_if.valid   <= 1'b0;
      byte_if.in_byte <= '0;
    end else begin
      send   = 1'b0;
      next_b = '0;
      if (byte_if.valid && byte_if.ready) begin
        deframe_byte(byte_if.in_byte);
        bytes_taken++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          if (stim_q[0].hold) begin
            if (pending_rec_q.size() == 0) begin
              void'(stim_q.pop_front());
              holds_done++;
            end
          end else begin
            next_b = stim_q[0].data;
            void'(stim_q.pop_front());
            send = 1'b1;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 30);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
              burst_left--;
            end
          end
        end
        byte_if.valid <= send;
        if (send) byte_if.in_byte <= next_b;
      end
    end
  end

  // Receiver: ready follows a stall mode that is drawn anew at the end of each random span.
  stall_mode_e stall_mode;
  int unsigned stall_span;
  logic [4:0]  stall_tick;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_if.ready <= 1'b0;
      stall_mode   <= STALL_NONE;
      stall_span   <= 0;
      stall_tick   <= '0;
    end else begin
      stall_tick <= stall_tick + 5'd1;
      if (stall_span == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_span <= $urandom_range(16, 160);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        STALL_NONE:  rec_if.ready <= 1'b1;
        STALL_COIN:  rec_if.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY: rec_if.ready <= ($urandom_range(0, 3) == 0);
        default:     rec_if.ready <= (stall_tick[4:3] != 2'd0);
      endcase
    end
  end

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  // Monitor: each record transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin : watch_records
    wsfd_result_t got;
    wsfd_result_t want;
    if (rst_ni && rec_if.valid && rec_if.ready) begin
      got = {rec_if.kind, rec_if.payload_byte, rec_if.frame_fin, rec_if.frame_opcode,
             rec_if.frame_masked, rec_if.payload_length, rec_if.last_of_frame};
      if (pending_rec_q.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = pending_rec_q.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("frame_fin", want.frame_fin, got.frame_fin);
        check_field("frame_opcode", want.frame_opcode, got.frame_opcode);
        check_field("frame_masked", want.frame_masked, got.frame_masked);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
        if (want.kind == KIND_HEADER) hdr_recs++;
        else pay_recs++;
      end
    end
  end

  // Watchdog: ends the run when neither channel has a transfer for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (rec_if.valid && rec_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_stream
    len_enc_e    enc;
    logic [63:0] len;
    int unsigned sel;
    byte_if.valid   = 1'b0;
    byte_if.in_byte = '0;
    rec_if.ready    = 1'b0;

    // Directed frames: empty unmasked frame, empty masked frame (header closes on the
    // last key byte), masked frame with reserved bits set and FIN clear, and a short
    // length sent in the 16-bit extended form.
    queue_frame(8'h89, 1'b0, LEN_SHORT, 64'd0, 32'h0000_0000, 0);
    queue_frame(8'h8A, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
    queue_frame(8'h71, 1'b1, LEN_SHORT, 64'd5, 32'hFF00_A55A, 5);
    queue_frame(8'h02, 1'b0, LEN_EXT16, 64'd2, 32'h0000_0000, 2);

    // Random back-to-back frames, mostly short, with every length encoding.
    while (stream_bytes < STREAM_BYTES) begin
      if (frames == 15 || $urandom_range(0, 19) == 0) stim_q.push_back('{hold: 1'b1, data: 8'h00});
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        enc = LEN_SHORT;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      end else if (sel < 17) begin
        enc = LEN_EXT16;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 400) : $urandom_range(0, 10);
      end else begin
        enc = LEN_EXT64;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 10);
      end
      queue_frame(8'($urandom), 1'($urandom_range(0, 1)), enc, len, $urandom, int'(len));
    end

    // Closing frame with an all-ones 64-bit length; only its first bytes are sent.
    queue_frame(8'h82, 1'b1, LEN_EXT64, '1, $urandom, 6);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != stream_bytes) @(posedge clk_i);
    while (pending_rec_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("stream of %0d bytes in %0d frames (%0d masked, %0d ext16, %0d ext64, %0d empty)",
             stream_bytes, frames, masked_frames, ext16_frames, ext64_frames, empty_frames);
    $display("checked %0d header records and %0d payload bytes, %0d drain holds, %0d errors",
             hdr_recs, pay_recs, holds_done, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
